// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define QRS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that one condition implies another on the same edge.
`define QRS_IMPLY(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

// ===== rtl/qrs_pkg.sv =====
package qrs_pkg;

   localparam int COEF_W     = 16;
   localparam int HALF_SHIFT = 31 - COEF_W;
   localparam int PROD_W     = 2 * COEF_W;
   localparam int DISC_W     = 35;
   localparam int ROOT_W     = 32;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int MAG_W      = RAD_W - 2 * HALF_SHIFT;
   localparam int REM_W      = ROOT_W + 4;
   localparam int NUM_W      = 35;
   localparam int DIVD_W     = NUM_W + 1;
   localparam int DIVS_W     = COEF_W + 1;
   localparam int OUT_W      = 40;
   localparam int IN_DATA_W  = 3 * COEF_W;
   localparam int OUT_DATA_W = 120;
   localparam int OUT_USER_W = 3;
   localparam int LANES      = 2;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [DISC_W-1:0] disc;
      logic                     cplx;
      logic                     fault;
   } sqrt_side_type;

   typedef struct packed {
      logic signed [DISC_W-1:0] disc;
      logic                     cplx;
      logic                     fault;
      logic [LANES-1:0]         neg;
   } div_side_type;

endpackage

// ===== rtl/quadratic_root_solver_top.sv =====
// Channel   Direction  tdata (low bit first)                          tuser
// req_      in         coef_a, coef_b, coef_c                         none
// rsp_      out        first_value, second_value, discriminant, pad   is_complex,
//                                                                     divide_fault, saturated
// One word enters per cycle while no result waits or rsp_tready is high.
// Each word passes through the 32-step square root and the 36-step divider pipelines.
// Reset is synchronous and clears only the valid bits along the pipeline.
// When a result waits and rsp_tready is low, the whole pipeline holds and
// req_tready drops; nothing is lost or repeated.
`include "assert_macros.svh"

module quadratic_root_solver_top import qrs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [IN_DATA_W-1:0]   req_tdata,   // coef_a, coef_b, coef_c
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [OUT_DATA_W-1:0]  rsp_tdata,   // first_value, second_value, discriminant, zeros
   output logic [OUT_USER_W-1:0]  rsp_tuser    // is_complex, divide_fault, saturated
);

   localparam logic signed [OUT_W:0] ROOT_MAX = (OUT_W+1)'((64'(1) << (OUT_W-1)) - 64'(1));
   localparam logic signed [OUT_W:0] ROOT_MIN = -ROOT_MAX - (OUT_W+1)'(1);

   logic enable;

   logic signed [COEF_W-1:0] coef_a, coef_b, coef_c;

   logic                     v0_ff;
   logic signed [PROD_W-1:0] bb_ff, ac_ff;
   logic signed [COEF_W-1:0] a0_ff, b0_ff;

   logic                     v1_ff;
   logic [MAG_W-1:0]         mag_ff;
   sqrt_side_type            side1_ff;
   logic signed [DISC_W-1:0] disc_in;

   logic                     sq_valid;
   logic [ROOT_W-1:0]        sq_root;
   sqrt_side_type            sq_side;

   logic                     v2_ff;
   logic signed [NUM_W-1:0]  num_ff [LANES];
   sqrt_side_type            side2_ff;
   logic signed [NUM_W-1:0]  nb, sx;

   logic                     v3_ff;
   logic [DIVD_W-1:0]        dvd_ff [LANES];
   logic [DIVS_W-1:0]        dvs_ff;
   div_side_type             side3_ff;
   logic [COEF_W-1:0]        abs_a;

   logic                     dv_valid;
   logic [DIVD_W-1:0]        dv_quot [LANES];
   div_side_type             dv_side;

   logic                     out_valid_ff;
   logic [OUT_W-1:0]         root_ff [LANES];
   logic signed [DISC_W-1:0] disc_ff;
   logic                     cplx_ff, fault_ff, sat_ff;
   logic [OUT_W-1:0]         root_in [LANES];
   logic [LANES-1:0]         clip;

   assign enable     = !out_valid_ff || rsp_tready;
   assign req_tready = enable;

   assign coef_a = req_tdata[COEF_W-1:0];
   assign coef_b = req_tdata[2*COEF_W-1:COEF_W];
   assign coef_c = req_tdata[3*COEF_W-1:2*COEF_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         v0_ff <= req_tvalid;
         v1_ff <= v0_ff;
         v2_ff <= sq_valid;
         v3_ff <= v2_ff;
         out_valid_ff <= dv_valid;
      end
   end

   // Products, then the discriminant and its magnitude.
   always_ff @(posedge clock) begin
      if (enable) begin
         bb_ff <= coef_b * coef_b;
         ac_ff <= coef_a * coef_c;
         a0_ff <= coef_a;
         b0_ff <= coef_b;
      end
   end

   assign disc_in = DISC_W'(bb_ff) - (DISC_W'(ac_ff) <<< 2);

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff         <= disc_in[DISC_W-1] ? MAG_W'(-disc_in) : MAG_W'(disc_in);
         side1_ff.coef_a <= a0_ff;
         side1_ff.coef_b <= b0_ff;
         side1_ff.disc   <= disc_in;
         side1_ff.cplx   <= disc_in[DISC_W-1];
         side1_ff.fault  <= (a0_ff == '0);
      end
   end

   qrs_isqrt_pipe u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (v1_ff),
      .in_rad    ({mag_ff, {(2*HALF_SHIFT){1'b0}}}),
      .in_side   (side1_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Numerators of the two results.
   assign nb = -(NUM_W'(sq_side.coef_b) <<< HALF_SHIFT);
   assign sx = $signed(NUM_W'(sq_root));

   always_ff @(posedge clock) begin
      if (enable) begin
         num_ff[0] <= sq_side.cplx ? nb : nb + sx;
         num_ff[1] <= sq_side.cplx ? sx : nb - sx;
         side2_ff  <= sq_side;
      end
   end

   // Rounded division: (2|num| + |a|) / (2|a|).
   assign abs_a = side2_ff.coef_a[COEF_W-1] ? COEF_W'(-side2_ff.coef_a)
                                            : COEF_W'(side2_ff.coef_a);

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int l = 0; l < LANES; l++) begin
            dvd_ff[l] <= {(num_ff[l][NUM_W-1] ? NUM_W'(-num_ff[l]) : NUM_W'(num_ff[l])), 1'b0}
                         + DIVD_W'(abs_a);
            side3_ff.neg[l] <= num_ff[l][NUM_W-1] != side2_ff.coef_a[COEF_W-1];
         end
         dvs_ff         <= {abs_a, 1'b0};
         side3_ff.disc  <= side2_ff.disc;
         side3_ff.cplx  <= side2_ff.cplx;
         side3_ff.fault <= side2_ff.fault;
      end
   end

   qrs_div_pipe u_div (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .in_valid    (v3_ff),
      .in_dividend (dvd_ff),
      .in_divisor  (dvs_ff),
      .in_side     (side3_ff),
      .out_valid   (dv_valid),
      .out_quot    (dv_quot),
      .out_side    (dv_side)
   );

   // Sign, clip and the divide-by-zero case.
   for (genvar l = 0; l < LANES; l++) begin : g_fix
      logic signed [OUT_W:0] val;
      assign val = dv_side.neg[l] ? -$signed((OUT_W+1)'(dv_quot[l]))
                                  : $signed((OUT_W+1)'(dv_quot[l]));
      always_comb begin
         clip[l] = 1'b0;
         priority if (dv_side.fault) begin
            root_in[l] = '0;
         end else if (val > ROOT_MAX) begin
            root_in[l] = OUT_W'(ROOT_MAX);
            clip[l]    = 1'b1;
         end else if (val < ROOT_MIN) begin
            root_in[l] = OUT_W'(ROOT_MIN);
            clip[l]    = 1'b1;
         end else begin
            root_in[l] = OUT_W'(val);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         root_ff[0] <= root_in[0];
         root_ff[1] <= root_in[1];
         disc_ff    <= dv_side.disc;
         cplx_ff    <= dv_side.cplx;
         fault_ff   <= dv_side.fault;
         sat_ff     <= |clip;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(OUT_DATA_W-2*OUT_W-DISC_W)'(0), disc_ff, root_ff[1], root_ff[0]};
   assign rsp_tuser  = {sat_ff, fault_ff, cplx_ff};

   `QRS_IMPLY(a_fault_zero, rsp_tvalid && fault_ff, root_ff[0] == '0 && root_ff[1] == '0, "fault word carries nonzero roots")
   `QRS_IMPLY(a_fault_nosat, rsp_tvalid && fault_ff, !sat_ff && !cplx_ff, "fault word flagged complex or clipped")
   `QRS_IMPLY(a_cplx_sign, rsp_tvalid && cplx_ff, disc_ff[DISC_W-1], "complex flag with nonnegative discriminant")
   `QRS_ASSERT(a_ready_free, !rsp_tvalid |-> req_tready, "input stalled with empty output")

endmodule

// ===== rtl/qrs_isqrt_pipe.sv =====
module qrs_isqrt_pipe import qrs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  logic [RAD_W-1:0]    in_rad,
   input  sqrt_side_type       in_side,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output sqrt_side_type       out_side
);

   logic                valid_ff [ROOT_W];
   logic [RAD_W-1:0]    rad_ff   [ROOT_W];
   logic [REM_W-1:0]    rem_ff   [ROOT_W];
   logic [ROOT_W-1:0]   root_ff  [ROOT_W];
   sqrt_side_type       side_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic                v_p;
      logic [RAD_W-1:0]    rad_p;
      logic [REM_W-1:0]    rem_p;
      logic [ROOT_W-1:0]   root_p;
      sqrt_side_type       side_p;
      logic [REM_W-1:0]    rem_sh;
      logic [REM_W-1:0]    trial;
      logic                ge;
      logic [REM_W-1:0]    rem_in;
      logic [ROOT_W-1:0]   root_in;
      logic [RAD_W-1:0]    rad_in;

      if (k == 0) begin : g_first
         assign v_p    = in_valid;
         assign rad_p  = in_rad;
         assign rem_p  = '0;
         assign root_p = '0;
         assign side_p = in_side;
      end else begin : g_next
         assign v_p    = valid_ff[k-1];
         assign rad_p  = rad_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      assign rem_sh  = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
      assign trial   = {2'b00, root_p, 2'b01};
      assign ge      = rem_sh >= trial;
      assign rem_in  = ge ? rem_sh - trial : rem_sh;
      assign root_in = {root_p[ROOT_W-2:0], ge};
      assign rad_in  = {rad_p[RAD_W-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rad_ff[k]  <= rad_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// ===== rtl/qrs_div_pipe.sv =====
module qrs_div_pipe import qrs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  logic [DIVD_W-1:0]   in_dividend [LANES],
   input  logic [DIVS_W-1:0]   in_divisor,
   input  div_side_type        in_side,
   output logic                out_valid,
   output logic [DIVD_W-1:0]   out_quot [LANES],
   output div_side_type        out_side
);

   logic                valid_ff [DIVD_W];
   logic [DIVS_W-1:0]   dvs_ff   [DIVD_W];
   div_side_type        side_ff  [DIVD_W];
   logic [DIVD_W-1:0]   dq_ff    [DIVD_W][LANES];
   logic [DIVS_W-1:0]   rem_ff   [DIVD_W][LANES];

   for (genvar k = 0; k < DIVD_W; k++) begin : g_step
      logic                v_p;
      logic [DIVS_W-1:0]   dvs_p;
      div_side_type        side_p;

      if (k == 0) begin : g_first
         assign v_p    = in_valid;
         assign dvs_p  = in_divisor;
         assign side_p = in_side;
      end else begin : g_next
         assign v_p    = valid_ff[k-1];
         assign dvs_p  = dvs_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            dvs_ff[k]  <= dvs_p;
            side_ff[k] <= side_p;
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DIVD_W-1:0]   dq_p;
         logic [DIVS_W-1:0]   rem_p;
         logic [DIVS_W:0]     rsh;
         logic                ge;
         logic [DIVS_W:0]     diff;

         if (k == 0) begin : g_first
            assign dq_p  = in_dividend[l];
            assign rem_p = '0;
         end else begin : g_next
            assign dq_p  = dq_ff[k-1][l];
            assign rem_p = rem_ff[k-1][l];
         end

         assign rsh  = {rem_p, dq_p[DIVD_W-1]};
         assign ge   = rsh >= {1'b0, dvs_p};
         assign diff = rsh - {1'b0, dvs_p};

         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k][l] <= ge ? diff[DIVS_W-1:0] : rsh[DIVS_W-1:0];
               dq_ff[k][l]  <= {dq_p[DIVD_W-2:0], ge};
            end
         end
      end
   end

   assign out_valid = valid_ff[DIVD_W-1];
   assign out_side  = side_ff[DIVD_W-1];
   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign out_quot[l] = dq_ff[DIVD_W-1][l];
   end

endmodule
